FILE: hdl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared definitions for the sorted region table
// Table geometry, command and status codes, sequencer states and the
// layout of one stored region.
// ----------------------------------------------------------------------------
package srt_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ADDR_BITS   = 64;
  localparam int unsigned AW          = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths on the stream ports
  localparam int unsigned FIELD_W     = 64;
  localparam int unsigned TOTAL_W     = 7;
  localparam int unsigned IN_DATA_W   = 136;
  localparam int unsigned OUT_DATA_W  = 144;

  // Command codes (tuser of the slave side)
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Status codes (tuser of the master side)
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  // Region type that never grants access
  localparam logic [2:0] GUARD_KIND = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RFIND,
    S_RSHIFT,
    S_LOOK,
    S_NOP
  } state_e;

  // One stored region
  typedef struct packed {
    logic [ADDR_BITS-1:0] start_addr;
    logic [ADDR_BITS-1:0] end_addr;
    logic [2:0]           kind;
    logic [2:0]           perms;
  } entry_t;

endpackage

FILE: hdl/sorted_region_table_with_access_check.sv
// ----------------------------------------------------------------------------
// sorted_region_table_with_access_check
// Sorted table of address regions with add, remove and access lookup.
// ----------------------------------------------------------------------------
// One command beat enters on the s_axis group: tuser carries the command
// (add, remove by start, lookup), tdata the region or the lookup address.
// Exactly one result beat leaves on the m_axis group: tuser carries the
// status, tdata the hit and allowed flags, the found region and the count.
// The table sits in a single-port-write, single-port-read memory with a
// registered read; a small sequencer walks it one entry per cycle.
//   add    : scans down from the top, moving each larger start up one slot,
//            then writes the new region into the gap.
//   remove : scans up to the match, then moves later entries down.
//   lookup : scans up until a hit, a start above the address or the last entry.
// Table full and unused codes finish in the no-op state. The final step
// loads the result register. s_axis_tready is high only between commands.
// Reset empties the table at once (entry count to zero, no clearing pass).
// A stalled receiver holds the result register; the next command may be
// taken meanwhile but its final step waits until the register frees.
// ----------------------------------------------------------------------------
module sorted_region_table_with_access_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command beat
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [1:0] command
  input  logic [1:0]                       s_axis_tuser_i,
  // [63:0] region_start, [127:64] region_end, [130:128] region_kind,
  // [133:131] perm_bits, [135:134] zero
  input  logic [srt_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // result beat
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [1:0] status
  output logic [1:0]                       m_axis_tuser_o,
  // [0] hit, [1] allowed, [65:2] found_start, [129:66] found_end,
  // [132:130] found_kind, [135:133] found_perms, [142:136] region_total,
  // [143] zero
  output logic [srt_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned AB = srt_pkg::ADDR_BITS;
  localparam int unsigned CW = srt_pkg::CNT_W;
  localparam int unsigned FW = srt_pkg::FIELD_W;

  // Sequencer and control state
  srt_pkg::state_e      state_q, state_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        held_q, held_d;
  logic                 m_valid_q;

  // Captured command
  logic [1:0]           cmd_q;
  logic [AB-1:0]        key_q;
  logic [AB-1:0]        end_q;
  logic [2:0]           kind_q;
  logic [2:0]           perm_q;

  // Result register
  logic [1:0]           res_status_q, res_status_d;
  logic                 res_hit_q, res_hit_d;
  logic                 res_allowed_q, res_allowed_d;
  logic [AB-1:0]        res_start_q, res_start_d;
  logic [AB-1:0]        res_end_q, res_end_d;
  logic [2:0]           res_kind_q, res_kind_d;
  logic [2:0]           res_perms_q, res_perms_d;
  logic [CW-1:0]        res_total_q;
  logic                 load;

  // Table memory
  srt_pkg::entry_t      mem [srt_pkg::TABLE_DEPTH];
  srt_pkg::entry_t      rd_q;
  srt_pkg::entry_t      wr_data;
  logic                 wr_en;
  logic [CW-1:0]        wr_idx;
  logic [CW-1:0]        rd_idx;

  // Decision terms
  logic                 s_fire;
  logic                 out_free;
  logic                 fin;
  logic                 gt;
  logic                 eq;
  logic                 inr;
  logic                 at_held;
  logic                 nxt_last;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Compare the current entry against the captured key
  assign gt       = rd_q.start_addr > key_q;
  assign eq       = rd_q.start_addr == key_q;
  assign inr      = (key_q >= rd_q.start_addr) && (key_q < rd_q.end_addr);
  assign at_held  = idx_q >= held_q;
  assign nxt_last = (idx_q + CW'(1)) >= held_q;

  // Flag the step that ends the command
  always_comb begin
    unique case (state_q)
      srt_pkg::S_IDLE:   fin = 1'b0;
      srt_pkg::S_ADD:    fin = (idx_q == '0) || !gt;
      srt_pkg::S_RFIND:  fin = at_held;
      srt_pkg::S_RSHIFT: fin = nxt_last;
      srt_pkg::S_LOOK:   fin = at_held || inr || gt;
      srt_pkg::S_NOP:    fin = 1'b1;
      default:           fin = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srt_pkg::S_IDLE: begin
        if (s_fire) begin
          case (s_axis_tuser_i)
            srt_pkg::CMD_ADD: begin
              state_d = (held_q == CW'(srt_pkg::TABLE_DEPTH)) ? srt_pkg::S_NOP : srt_pkg::S_ADD;
            end
            srt_pkg::CMD_REMOVE: state_d = srt_pkg::S_RFIND;
            srt_pkg::CMD_LOOKUP: state_d = srt_pkg::S_LOOK;
            default:             state_d = srt_pkg::S_NOP;
          endcase
        end
      end
      srt_pkg::S_RFIND: begin
        if (fin) begin
          if (out_free) state_d = srt_pkg::S_IDLE;
        end else if (eq) begin
          state_d = srt_pkg::S_RSHIFT;
        end
      end
      srt_pkg::S_ADD, srt_pkg::S_RSHIFT, srt_pkg::S_LOOK, srt_pkg::S_NOP: begin
        if (fin && out_free) state_d = srt_pkg::S_IDLE;
      end
      default: state_d = srt_pkg::S_IDLE;
    endcase
  end

  // Datapath: read and write addresses, counters and result
  always_comb begin
    idx_d         = idx_q;
    held_d        = held_q;
    wr_en         = 1'b0;
    wr_idx        = idx_q;
    wr_data       = rd_q;
    rd_idx        = idx_q;
    load          = 1'b0;
    res_status_d  = srt_pkg::STAT_OK;
    res_hit_d     = 1'b0;
    res_allowed_d = 1'b0;
    res_start_d   = '0;
    res_end_d     = '0;
    res_kind_d    = '0;
    res_perms_d   = '0;
    unique case (state_q)
      srt_pkg::S_IDLE: begin
        rd_idx = (s_axis_tuser_i == srt_pkg::CMD_ADD) ? (held_q - CW'(1)) : '0;
        if (s_fire) begin
          idx_d = (s_axis_tuser_i == srt_pkg::CMD_ADD) ? held_q : '0;
        end
      end
      srt_pkg::S_ADD: begin
        rd_idx = idx_q - CW'(1);
        if (fin) begin
          // place the new region in the gap
          if (out_free) begin
            wr_en              = 1'b1;
            wr_data.start_addr = key_q;
            wr_data.end_addr   = end_q;
            wr_data.kind       = kind_q;
            wr_data.perms      = perm_q;
            held_d             = held_q + CW'(1);
            load               = 1'b1;
          end
        end else begin
          // move the larger entry up one slot
          wr_en  = 1'b1;
          idx_d  = idx_q - CW'(1);
          rd_idx = idx_q - CW'(2);
        end
      end
      srt_pkg::S_RFIND: begin
        rd_idx = idx_q + CW'(1);
        if (fin) begin
          if (out_free) begin
            load         = 1'b1;
            res_status_d = srt_pkg::STAT_MISS;
          end
        end else if (!eq) begin
          idx_d = idx_q + CW'(1);
        end
      end
      srt_pkg::S_RSHIFT: begin
        rd_idx = idx_q + CW'(1);
        if (fin) begin
          if (out_free) begin
            held_d = held_q - CW'(1);
            load   = 1'b1;
          end
        end else begin
          // close the gap: move the next entry down
          wr_en  = 1'b1;
          idx_d  = idx_q + CW'(1);
          rd_idx = idx_q + CW'(2);
        end
      end
      srt_pkg::S_LOOK: begin
        if (fin) begin
          if (out_free) begin
            load = 1'b1;
            if (!at_held && inr) begin
              res_hit_d     = 1'b1;
              res_allowed_d = (rd_q.kind != srt_pkg::GUARD_KIND)
                              && ((rd_q.perms & perm_q) == perm_q);
              res_start_d   = rd_q.start_addr;
              res_end_d     = rd_q.end_addr;
              res_kind_d    = rd_q.kind;
              res_perms_d   = rd_q.perms;
            end else begin
              res_status_d = srt_pkg::STAT_MISS;
            end
          end
        end else begin
          idx_d  = idx_q + CW'(1);
          rd_idx = idx_q + CW'(1);
        end
      end
      srt_pkg::S_NOP: begin
        if (out_free) begin
          load         = 1'b1;
          res_status_d = (cmd_q == srt_pkg::CMD_ADD) ? srt_pkg::STAT_FULL : srt_pkg::STAT_OK;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  // Table memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx[srt_pkg::AW-1:0]] <= wr_data;
    end
    rd_q <= mem[rd_idx[srt_pkg::AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srt_pkg::S_IDLE;
      idx_q     <= '0;
      held_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      held_q  <= held_d;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Capture the command beat
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q  <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i[AB-1:0];
      end_q  <= s_axis_tdata_i[FW+AB-1:FW];
      kind_q <= s_axis_tdata_i[2*FW+2:2*FW];
      perm_q <= s_axis_tdata_i[2*FW+5:2*FW+3];
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_status_q  <= res_status_d;
      res_hit_q     <= res_hit_d;
      res_allowed_q <= res_allowed_d;
      res_start_q   <= res_start_d;
      res_end_q     <= res_end_d;
      res_kind_q    <= res_kind_d;
      res_perms_q   <= res_perms_d;
      res_total_q   <= held_d;
    end
  end

  assign s_axis_tready_o = (state_q == srt_pkg::S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = res_status_q;
  assign m_axis_tdata_o  = {1'b0,
                            srt_pkg::TOTAL_W'(res_total_q),
                            res_perms_q,
                            res_kind_q,
                            FW'(res_end_q),
                            FW'(res_start_q),
                            res_allowed_q,
                            res_hit_q};

  // Checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(srt_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_idx <= held_q) && (wr_idx < CW'(srt_pkg::TABLE_DEPTH)))
    else $error("table write beyond held entries");

  a_lookup_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srt_pkg::S_LOOK) |=> (held_q == $past(held_q)))
    else $error("lookup changed the entry count");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (state_q == srt_pkg::S_ADD)) |=> (held_q == $past(held_q) + CW'(1)))
    else $error("add did not grow the table by one");

  a_no_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |-> !load)
    else $error("result overwritten while stalled");

endmodule
